@@ rtl/keyed_rw_lock_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - assertion macros
// Concurrent check wrappers; they are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_RW_LOCK_TABLE_CORE_DEFINES_SVH
`define KEYED_RW_LOCK_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define KRW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// checked on every edge, reset included
`define KRW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define KRW_ASSERT(lbl, prop, msg)
`define KRW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/krw_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - package
// Fixed field widths, status codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package krw_pkg;

    localparam int KEY_W       = 64;
    localparam int MASK_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 72;   // 71 field bits, padded to bytes
    localparam int OUT_TDATA_W = 8;    // 4 field bits, padded to bytes

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_GRANTED    = 3'd0;
    localparam status_t ST_CONFLICT   = 3'd1;
    localparam status_t ST_RETRY      = 3'd2;
    localparam status_t ST_FULL       = 3'd3;
    localparam status_t ST_RELEASED   = 3'd4;
    localparam status_t ST_NOT_FOUND  = 3'd5;
    localparam status_t ST_OVERFLOW   = 3'd6;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic scan;    // issue one table read, advance pointer
        logic exec;    // decide, write back, load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;   // pointer is at the final entry
    } stat_t;

endpackage

@@ rtl/keyed_rw_lock_table_core.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - top level
// Reader/writer lock table keyed by a 64-bit sector id, with per-type reader
// counts, a writer mask and a holder count per entry.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                      Contents
//  -------  ---  -------------------------  --------------------------------
//  request  in   s_tvalid/s_tready/s_tdata  acquire or release of one sector
//                s_tuser                    (tuser carries the request kind)
//  result   out  m_tvalid/m_tready/m_tdata  status and wake for that request
//
// Result shows after the request transfer, the scan, a flush state for the last
// compare and the execute state that decides and writes back; the scan does one
// entry RAM read per cycle (single port). The next transfer can come in the cycle
// after execute at the earliest. Reset (aresetn low,
// synchronous) clears the valid flags and control state, not the RAM; RAM is read behind a set flag.
// A waiting result never blocks s_tready; m_tready stalls hold only execute.
//
module keyed_rw_lock_table_core #(
    parameter int TABLE_ENTRIES = 16,   // 1..256
    parameter int FILE_TYPES    = 3,    // 1..8
    parameter int COUNT_BITS    = 8     // 2..16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] sector_id, [66:64] read_mask, [69:67] write_mask,
    // [70] wait_flag, [71] zero
    input  logic [krw_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [0] req_type (0 acquire, 1 release)
    input  logic                            s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [3] wake, [7:4] zero
    output logic [krw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    krw_pkg::cmd_t  cmd;    // controller to datapath
    krw_pkg::stat_t stat;   // datapath to controller

    // sequencing and result valid flag
    krw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // entry store, key match, lock decision, result payload
    krw_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FILE_TYPES    (FILE_TYPES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

@@ rtl/krw_ram.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - generic RAM
// Single port, write-enable, registered read (read-before-write).
// ----------------------------------------------------------------------------
module krw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/krw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - controller
// Sequences accept, table scan, flush, execute; owns the result valid flag.
// ----------------------------------------------------------------------------
`include "keyed_rw_lock_table_core_defines.svh"

module krw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  krw_pkg::stat_t stat,
    output krw_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fire;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // result register free now or emptied this cycle
    assign fire = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    always_comb begin
        cmd.load = s_tvalid && s_tready;
        cmd.scan = (state_reg == S_SCAN);
        cmd.exec = fire;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_last) state_next = S_FLUSH;
            end
            S_FLUSH: state_next = S_EXEC;
            S_EXEC: begin
                if (fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `KRW_ASSERT(a_accept_scans, s_tvalid && s_tready |=> state_reg == S_SCAN, "accept without scan")
    `KRW_ASSERT(a_exec_room, cmd.exec |-> !out_valid_reg || m_tready, "result overwritten")
    `KRW_ASSERT(a_exec_shows, cmd.exec |=> out_valid_reg, "result lost after execute")
    `KRW_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !out_valid_reg && state_reg == S_IDLE, "reset not clean")

endmodule

@@ rtl/krw_dp.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - datapath
// Request register, entry RAM scan with key compare, lock decision and
// write-back, valid flags and result register.
// ----------------------------------------------------------------------------
module krw_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FILE_TYPES    = 3,
    parameter int COUNT_BITS    = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  krw_pkg::cmd_t                      cmd,
    output krw_pkg::stat_t                     stat,
    input  logic [krw_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic [krw_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int ACT    = (FILE_TYPES < krw_pkg::MASK_W) ? FILE_TYPES : krw_pkg::MASK_W;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEY_W  = krw_pkg::KEY_W;
    localparam int RDR_LO = KEY_W + ACT;
    localparam int HLD_LO = RDR_LO + ACT * COUNT_BITS;
    localparam int REC_W  = HLD_LO + COUNT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // request register
    logic                release_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ACT-1:0]      rd_reg, wr_reg;
    logic                wait_reg;

    // scan state
    logic [IDX_W-1:0]    ptr_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                hit_reg, free_reg;
    logic [IDX_W-1:0]    hit_idx_reg, free_idx_reg;
    logic [REC_W-1:0]    hit_rec_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [krw_pkg::STATUS_W-1:0] status_reg;
    logic                wake_reg;

    logic [REC_W-1:0]    rdata, wdata;
    logic [IDX_W-1:0]    addr, tgt_idx;
    logic                we;

    // decision
    logic [ACT-1:0]      base_wm, new_wm;
    cnt_t                base_rc [ACT];
    cnt_t                new_rc  [ACT];
    cnt_t                base_hold, new_hold;
    logic                conflict, saturate, any_req, set_valid, clr_valid;
    krw_pkg::status_t    status_c, deny_c;

    assign stat.scan_last = (ptr_reg == LAST_IDX);

    krw_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign tgt_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign addr    = cmd.exec ? tgt_idx : ptr_reg;

    always_comb begin
        base_wm   = hit_reg ? hit_rec_reg[KEY_W +: ACT] : '0;
        base_hold = hit_reg ? hit_rec_reg[HLD_LO +: COUNT_BITS] : '0;
        conflict  = |((rd_reg | wr_reg) & base_wm);
        saturate  = (base_hold == '1);
        for (int t = 0; t < ACT; t++) begin
            base_rc[t] = hit_reg ? hit_rec_reg[RDR_LO + t * COUNT_BITS +: COUNT_BITS] : '0;
            if (wr_reg[t] && base_rc[t] != '0) conflict = 1'b1;
            if (rd_reg[t] && base_rc[t] == '1) saturate = 1'b1;
        end
        any_req = |(rd_reg | wr_reg);
        deny_c  = wait_reg ? krw_pkg::ST_RETRY : krw_pkg::ST_CONFLICT;

        set_valid = 1'b0;
        clr_valid = 1'b0;
        new_wm    = base_wm;
        new_hold  = base_hold;
        for (int t = 0; t < ACT; t++) new_rc[t] = base_rc[t];

        if (release_reg == krw_pkg::REQ_ACQUIRE) begin
            if (!any_req) begin
                status_c = deny_c;
            end else if (!hit_reg && !free_reg) begin
                status_c = krw_pkg::ST_FULL;
            end else if (hit_reg && conflict) begin
                status_c = deny_c;
            end else if (hit_reg && saturate) begin
                status_c = krw_pkg::ST_OVERFLOW;
            end else begin
                status_c  = krw_pkg::ST_GRANTED;
                set_valid = 1'b1;
                new_wm    = base_wm | wr_reg;
                new_hold  = base_hold + cnt_t'(1);
                for (int t = 0; t < ACT; t++)
                    new_rc[t] = base_rc[t] + cnt_t'(rd_reg[t]);
            end
        end else begin
            if (!hit_reg) begin
                status_c = krw_pkg::ST_NOT_FOUND;
            end else begin
                status_c = krw_pkg::ST_RELEASED;
                new_wm   = base_wm & ~wr_reg;
                new_hold = (base_hold != '0) ? base_hold - cnt_t'(1) : base_hold;
                for (int t = 0; t < ACT; t++)
                    if (rd_reg[t] && base_rc[t] != '0) new_rc[t] = base_rc[t] - cnt_t'(1);
                // holders gone: entry freed, its fields are not read again
                clr_valid = (new_hold == '0);
            end
        end

        wdata[KEY_W-1:0]             = key_reg;
        wdata[KEY_W +: ACT]          = new_wm;
        wdata[HLD_LO +: COUNT_BITS]  = new_hold;
        for (int t = 0; t < ACT; t++)
            wdata[RDR_LO + t * COUNT_BITS +: COUNT_BITS] = new_rc[t];
    end

    assign we = cmd.exec && (set_valid || status_c == krw_pkg::ST_RELEASED);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            valid_reg   <= '0;
        end else begin
            cmp_vld_reg <= cmd.scan;
            if (cmd.load) begin
                ptr_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else begin
                if (cmd.scan) ptr_reg <= ptr_reg + IDX_W'(1);
                if (cmp_vld_reg && valid_reg[cmp_idx_reg] && !hit_reg &&
                    rdata[KEY_W-1:0] == key_reg) begin
                    hit_reg <= 1'b1;
                end
                if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_reg) begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.exec && set_valid) valid_reg[tgt_idx] <= 1'b1;
            if (cmd.exec && clr_valid) valid_reg[tgt_idx] <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            release_reg <= s_tuser;
            key_reg     <= s_tdata[KEY_W-1:0];
            rd_reg      <= s_tdata[KEY_W +: ACT];
            wr_reg      <= s_tdata[KEY_W + krw_pkg::MASK_W +: ACT];
            wait_reg    <= s_tdata[KEY_W + 2 * krw_pkg::MASK_W];
        end
        cmp_idx_reg <= ptr_reg;
        if (cmp_vld_reg && valid_reg[cmp_idx_reg] && !hit_reg &&
            rdata[KEY_W-1:0] == key_reg) begin
            hit_idx_reg <= cmp_idx_reg;
            hit_rec_reg <= rdata;
        end
        if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.exec) begin
            status_reg <= status_c;
            wake_reg   <= (status_c == krw_pkg::ST_RELEASED);
        end
    end

    assign m_tdata = {{(krw_pkg::OUT_TDATA_W - krw_pkg::STATUS_W - 1){1'b0}},
                      wake_reg, status_reg};

endmodule

@@ verif/keyed_rw_lock_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// Keyed RW lock table - testbench
// Drives acquire and release requests through the request stream and checks
// every result transfer against an in-bench lock table model. A short table
// of directed requests comes first, then randomised traffic: lock/unlock
// sequences on a small key pool, table fill, counter saturation, waiter
// retries after a wake, and stray requests. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module keyed_rw_lock_table_core_tb;

    localparam int N_ENT      = 16;
    localparam int N_TYPES    = 3;
    localparam int CNT_BITS   = 8;
    localparam int CNT_MAX    = (1 << CNT_BITS) - 1;
    localparam logic [krw_pkg::MASK_W-1:0] TYPE_MASK =
        krw_pkg::MASK_W'((1 << N_TYPES) - 1);
    localparam int N_ITEMS    = 1500;
    localparam int POOL_SIZE  = 12;
    localparam int N_DIRECTED = 23;

    localparam logic [krw_pkg::KEY_W-1:0] K_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [krw_pkg::KEY_W-1:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [krw_pkg::KEY_W-1:0] K_TOP  = 64'h8000_0000_0000_0000;
    localparam logic [krw_pkg::KEY_W-1:0] K_ALT0 = 64'h5555_5555_5555_5555;
    localparam logic [krw_pkg::KEY_W-1:0] K_ALT1 = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        logic                       kind;       // REQ_ACQUIRE / REQ_RELEASE
        logic [krw_pkg::KEY_W-1:0]  sector;
        logic [krw_pkg::MASK_W-1:0] rd;
        logic [krw_pkg::MASK_W-1:0] wr;
        logic                       wait_flag;
    } lock_req_t;

    typedef struct packed {
        krw_pkg::status_t status;
        logic             wake;
    } lock_result_t;

    typedef struct packed {
        lock_req_t    req;
        logic         has_exp;   // expected result typed in below
        lock_result_t exp;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [krw_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [krw_pkg::OUT_TDATA_W-1:0] m_tdata;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    keyed_rw_lock_table_core #(
        .TABLE_ENTRIES (N_ENT),
        .FILE_TYPES    (N_TYPES),
        .COUNT_BITS    (CNT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Lock table model: its own copy of the table, updated in transfer order
    // ------------------------------------------------------------------------
    bit [krw_pkg::KEY_W-1:0]  lk_key     [N_ENT];
    bit                       lk_valid   [N_ENT];
    bit [krw_pkg::MASK_W-1:0] lk_wmask   [N_ENT];
    int unsigned              lk_readers [N_ENT][N_TYPES];
    int unsigned              lk_holders [N_ENT];

    function automatic lock_result_t apply_request(input lock_req_t r);
        lock_result_t               res;
        logic [krw_pkg::MASK_W-1:0] rd;
        logic [krw_pkg::MASK_W-1:0] wr;
        krw_pkg::status_t           deny;
        int                         hit;
        int                         slot;
        bit                         clash;
        bit                         sat;
        rd   = r.rd & TYPE_MASK;
        wr   = r.wr & TYPE_MASK;
        hit  = -1;
        slot = -1;
        // walk downwards so the lowest free entry wins
        for (int e = N_ENT - 1; e >= 0; e--) begin
            if (lk_valid[e] && lk_key[e] == r.sector) hit = e;
            if (!lk_valid[e]) slot = e;
        end
        res.status = krw_pkg::ST_GRANTED;
        res.wake   = 1'b0;
        if (r.kind == krw_pkg::REQ_ACQUIRE) begin
            deny = r.wait_flag ? krw_pkg::ST_RETRY : krw_pkg::ST_CONFLICT;
            if ((rd | wr) == '0) begin
                res.status = deny;
            end else if (hit < 0 && slot < 0) begin
                res.status = krw_pkg::ST_FULL;
            end else begin
                clash = 1'b0;
                sat   = 1'b0;
                if (hit >= 0) begin
                    clash = ((rd | wr) & lk_wmask[hit]) != '0;
                    sat   = lk_holders[hit] >= CNT_MAX;
                    for (int t = 0; t < N_TYPES; t++) begin
                        if (wr[t] && lk_readers[hit][t] != 0) clash = 1'b1;
                        if (rd[t] && lk_readers[hit][t] >= CNT_MAX) sat = 1'b1;
                    end
                end else begin
                    // new sector takes the free entry
                    hit              = slot;
                    lk_valid[hit]    = 1'b1;
                    lk_key[hit]      = r.sector;
                    lk_wmask[hit]    = '0;
                    lk_holders[hit]  = 0;
                    for (int t = 0; t < N_TYPES; t++) lk_readers[hit][t] = 0;
                end
                if (clash) begin
                    res.status = deny;
                end else if (sat) begin
                    res.status = krw_pkg::ST_OVERFLOW;
                end else begin
                    for (int t = 0; t < N_TYPES; t++)
                        if (rd[t]) lk_readers[hit][t]++;
                    lk_wmask[hit]   = lk_wmask[hit] | wr;
                    lk_holders[hit] = lk_holders[hit] + 1;
                end
            end
        end else if (hit < 0) begin
            res.status = krw_pkg::ST_NOT_FOUND;
        end else begin
            // counts stop at zero; entry freed once no holder is left
            for (int t = 0; t < N_TYPES; t++)
                if (rd[t] && lk_readers[hit][t] != 0) lk_readers[hit][t]--;
            lk_wmask[hit] = lk_wmask[hit] & ~wr;
            if (lk_holders[hit] != 0) lk_holders[hit] = lk_holders[hit] - 1;
            if (lk_holders[hit] == 0) begin
                lk_valid[hit] = 1'b0;
                lk_wmask[hit] = '0;
                for (int t = 0; t < N_TYPES; t++) lk_readers[hit][t] = 0;
            end
            res.status = krw_pkg::ST_RELEASED;
            res.wake   = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: oldest expectation against each result transfer
    // ------------------------------------------------------------------------
    lock_result_t result_q[$];
    int           err_count = 0;
    int           ready_calm = 0;
    int           ready_hold = 0;

    task automatic check_result(input logic [krw_pkg::OUT_TDATA_W-1:0] data);
        lock_result_t want;
        lock_result_t seen;
        seen.status = data[krw_pkg::STATUS_W-1:0];
        seen.wake   = data[krw_pkg::STATUS_W];
        if (result_q.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result, expected none, got status %0d wake %0d",
                     $time, seen.status, seen.wake);
        end else begin
            want = result_q.pop_front();
            if (seen.status !== want.status) begin
                err_count++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, seen.status);
            end
            if (seen.wake !== want.wake) begin
                err_count++;
                $display("%0t: wake mismatch, expected %0d, got %0d",
                         $time, want.wake, seen.wake);
            end
        end
    endtask

    // receiver back-pressure: mostly ready, short and long stalls, calm runs
    function automatic logic next_ready();
        int pick;
        if (ready_calm > 0) begin
            ready_calm--;
            return 1'b1;
        end
        if (ready_hold > 0) begin
            ready_hold--;
            return 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            ready_calm = $urandom_range(50, 200);
            return 1'b1;
        end
        if (pick < 5) begin
            ready_hold = $urandom_range(15, 40);
            return 1'b0;
        end
        if (pick < 25) begin
            ready_hold = $urandom_range(0, 3);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // values sampled here are the ones before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result(m_tdata);
        end
        m_tready <= next_ready();
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    int          items_sent = 0;
    int          send_calm  = 0;
    bit          wake_seen  = 1'b0;
    lock_req_t   held_q[$];    // granted locks not yet given back
    lock_req_t   retry_q[$];   // denied with wait_flag, retried after a wake
    logic [krw_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    // directed requests; expected result typed in where it is obvious
    dir_row_t directed_rows [N_DIRECTED] = '{
        // release and empty acquires straight after reset
        '{'{krw_pkg::REQ_RELEASE, K_ZERO, 3'd0, 3'd0, 1'b0}, 1'b1, '{krw_pkg::ST_NOT_FOUND, 1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ZERO, 3'd0, 3'd0, 1'b0}, 1'b1, '{krw_pkg::ST_CONFLICT,  1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ZERO, 3'd0, 3'd0, 1'b1}, 1'b1, '{krw_pkg::ST_RETRY,     1'b0}},
        // readers on every type, then writers refused
        '{'{krw_pkg::REQ_ACQUIRE, K_ONES, 3'd7, 3'd0, 1'b0}, 1'b1, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ONES, 3'd0, 3'd1, 1'b0}, 1'b1, '{krw_pkg::ST_CONFLICT,  1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ONES, 3'd0, 3'd1, 1'b1}, 1'b1, '{krw_pkg::ST_RETRY,     1'b0}},
        // writer on every type, then reader refused
        '{'{krw_pkg::REQ_ACQUIRE, K_ZERO, 3'd0, 3'd7, 1'b0}, 1'b1, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ZERO, 3'd1, 3'd0, 1'b1}, 1'b1, '{krw_pkg::ST_RETRY,     1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ONES, 3'd7, 3'd0, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_ZERO, 3'd0, 3'd7, 1'b0}, 1'b1, '{krw_pkg::ST_RELEASED,  1'b1}},
        '{'{krw_pkg::REQ_RELEASE, K_ZERO, 3'd7, 3'd7, 1'b1}, 1'b1, '{krw_pkg::ST_NOT_FOUND, 1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_ONES, 3'd7, 3'd0, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_ONES, 3'd0, 3'd0, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        // mixed masks on one sector; release of types not held
        '{'{krw_pkg::REQ_ACQUIRE, K_TOP,  3'd2, 3'd5, 1'b1}, 1'b1, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_TOP,  3'd0, 3'd2, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_TOP,  3'd2, 3'd0, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_TOP,  3'd4, 3'd0, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_TOP,  3'd7, 3'd7, 1'b0}, 1'b0, '{krw_pkg::ST_GRANTED,   1'b0}},
        // two sectors side by side
        '{'{krw_pkg::REQ_RELEASE, K_ALT0, 3'd0, 3'd0, 1'b0}, 1'b1, '{krw_pkg::ST_NOT_FOUND, 1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ALT1, 3'd5, 3'd2, 1'b1}, 1'b1, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_ACQUIRE, K_ALT0, 3'd2, 3'd5, 1'b0}, 1'b1, '{krw_pkg::ST_GRANTED,   1'b0}},
        '{'{krw_pkg::REQ_RELEASE, K_ALT1, 3'd0, 3'd0, 1'b0}, 1'b1, '{krw_pkg::ST_RELEASED,  1'b1}},
        '{'{krw_pkg::REQ_RELEASE, K_ALT0, 3'd7, 3'd7, 1'b0}, 1'b1, '{krw_pkg::ST_RELEASED,  1'b1}}
    };

    // sender gaps: mostly none or short, a few long, calm runs now and then
    function automatic int pick_gap();
        int pick;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            send_calm = $urandom_range(30, 100);
            return 0;
        end
        if (pick < 6) return $urandom_range(15, 40);
        if (pick < 30) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [krw_pkg::KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // one request transfer; the model is stepped once it is accepted
    task automatic send_request(input lock_req_t r, input logic typed,
                                input lock_result_t typed_res,
                                output lock_result_t got);
        int           gap;
        lock_result_t pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {1'b0, r.wait_flag, r.wr, r.rd, r.sector};
        do @(posedge aclk); while (!s_tready);
        pred = apply_request(r);
        result_q.push_back(typed ? typed_res : pred);
        got = pred;
        items_sent++;
    endtask

    // request plus lock and waiter bookkeeping
    task automatic do_request(input lock_req_t r);
        lock_result_t got;
        send_request(r, 1'b0, '0, got);
        if (got.status == krw_pkg::ST_GRANTED) held_q.push_back(r);
        if (got.status == krw_pkg::ST_RETRY && retry_q.size() < 8) retry_q.push_back(r);
        if (got.status == krw_pkg::ST_RELEASED) wake_seen = 1'b1;
    endtask

    task automatic give_back_one(input logic corrupt);
        lock_req_t r;
        int        idx;
        idx = $urandom_range(0, held_q.size() - 1);
        r   = held_q[idx];
        held_q.delete(idx);
        r.kind      = krw_pkg::REQ_RELEASE;
        r.wait_flag = 1'($urandom_range(0, 1));
        if (corrupt) begin
            r.rd = 3'($urandom_range(0, 7));
            r.wr = 3'($urandom_range(0, 7));
        end
        do_request(r);
    endtask

    task automatic drain_holds();
        while (held_q.size() > 0) give_back_one(1'b0);
    endtask

    // hold-off: no new request until every result is back
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // drive one entry to the holder and reader limits and back down
    task automatic saturate_one_entry();
        lock_req_t    r;
        lock_result_t got;
        r = '{krw_pkg::REQ_ACQUIRE, rand_key(), 3'd1, 3'd0, 1'b0};
        repeat (CNT_MAX) send_request(r, 1'b0, '0, got);
        r.rd = 3'd2;                                  // holder count full
        send_request(r, 1'b0, '0, got);
        r = '{krw_pkg::REQ_RELEASE, r.sector, 3'd0, 3'd0, 1'b0};
        send_request(r, 1'b0, '0, got);
        r = '{krw_pkg::REQ_ACQUIRE, r.sector, 3'd1, 3'd0, 1'b0}; // reader count full
        send_request(r, 1'b0, '0, got);
        r.rd = 3'd2;
        send_request(r, 1'b0, '0, got);
        r = '{krw_pkg::REQ_ACQUIRE, r.sector, 3'd0, 3'd1, 1'b1}; // conflict beats overflow
        send_request(r, 1'b0, '0, got);
        r = '{krw_pkg::REQ_RELEASE, r.sector, 3'd3, 3'd0, 1'b0};
        repeat (CNT_MAX + 1) send_request(r, 1'b0, '0, got);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        lock_req_t    r;
        lock_result_t got;
        int           pick;
        bit           sat_done;
        sat_done = 1'b0;
        // pairs of keys one bit apart test the exact key compare
        for (int i = 0; i < POOL_SIZE; i += 2) begin
            key_pool[i]     = rand_key();
            key_pool[i + 1] = key_pool[i] ^ (64'd1 << $urandom_range(0, 63));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_exp,
                         directed_rows[i].exp, got);
        pause_until_drained();

        while (items_sent < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (!sat_done && items_sent >= 500) begin
                drain_holds();
                pause_until_drained();
                saturate_one_entry();
                sat_done = 1'b1;
            end else if (wake_seen && retry_q.size() > 0 && pick < 30) begin
                // a waiter tries again after a wake
                do_request(retry_q.pop_front());
                if (retry_q.size() == 0) wake_seen = 1'b0;
            end else if (pick < 72) begin
                if (held_q.size() > 0 && ($urandom_range(0, 1) || held_q.size() > 40)) begin
                    give_back_one($urandom_range(0, 9) == 0);
                end else begin
                    r.kind      = krw_pkg::REQ_ACQUIRE;
                    r.sector    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                    r.rd        = 3'($urandom_range(0, 7));
                    r.wr        = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, 7));
                    r.wait_flag = 1'($urandom_range(0, 1));
                    do_request(r);
                end
            end else if (pick < 84) begin
                // stray traffic: unknown releases, stray masks, one-off keys
                r.kind      = $urandom_range(0, 2) != 0 ? krw_pkg::REQ_RELEASE
                                                        : krw_pkg::REQ_ACQUIRE;
                r.sector    = $urandom_range(0, 1) ? rand_key()
                                                   : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                r.rd        = 3'($urandom_range(0, 7));
                r.wr        = 3'($urandom_range(0, 7));
                r.wait_flag = 1'($urandom_range(0, 1));
                do_request(r);
            end else if (pick < 90) begin
                // fill the table past its size, then give half back
                repeat (N_ENT + 2) begin
                    r = '{krw_pkg::REQ_ACQUIRE, rand_key(), 3'($urandom_range(1, 7)),
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))};
                    do_request(r);
                end
                repeat (held_q.size() / 2) give_back_one(1'b0);
            end else if (held_q.size() > 0) begin
                repeat ($urandom_range(1, held_q.size())) give_back_one(1'b0);
            end
        end
        drain_holds();
        s_tvalid <= 1'b0;

        while (result_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit, well beyond the slowest correct run
    initial begin : watchdog
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
